// ===== design/homogeneous_transform_engine_assert.svh =====
// Assertion macros shared by the checker of the transform engine.
`ifndef HOMOGENEOUS_TRANSFORM_ENGINE_ASSERT_SVH
`define HOMOGENEOUS_TRANSFORM_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/hte_pkg.sv =====
// Shared types and constants of the homogeneous transform engine.
package hte_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int IN_DATA_W = 4 * WORD_W;
  localparam int DIV_NUM_W = WORD_W + FRAC_W + 1;

  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_W;
  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [3:0] CMD_IDENT     = 4'd0;
  localparam logic [3:0] CMD_TRANSLATE = 4'd1;
  localparam logic [3:0] CMD_SCALE     = 4'd2;
  localparam logic [3:0] CMD_ROT_X     = 4'd3;
  localparam logic [3:0] CMD_ROT_Y     = 4'd4;
  localparam logic [3:0] CMD_ROT_Z     = 4'd5;
  localparam logic [3:0] CMD_PERSP     = 4'd6;
  localparam logic [3:0] CMD_POINT     = 4'd7;
  localparam logic [3:0] CMD_HOMOG     = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       load_ident;
    logic       mode_mat;
    logic       mul_en;
    logic       acc_en;
    logic       rnd_en;
    logic       div_start;
    logic       div_recip;
    logic [1:0] div_sel;
    logic       load_out;
    logic [3:0] cmd_code;
    logic [3:0] idx;
    logic [1:0] k;
  } hte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_zero;
    logic r3_zero;
    logic div_busy;
    logic out_free;
  } hte_stat_t;

endpackage

// ===== design/hte_ctrl.sv =====
// Sequencer of the transform engine: steps products, rounding, divides and output.
module hte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [3:0]        s_tuser,
  input  hte_pkg::hte_stat_t stat,
  output hte_pkg::hte_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_DIVS = 3'd5;
  localparam logic [2:0] S_DIVW = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] cmd_code, cmd_code_next;
  logic [3:0] idx, idx_next;
  logic [1:0] k, k_next;
  logic [1:0] d, d_next;
  logic       mode_mat, mode_mat_next;
  logic       div_recip, div_recip_next;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd_code  <= hte_pkg::CMD_IDENT;
      idx       <= '0;
      k         <= '0;
      d         <= '0;
      mode_mat  <= 1'b0;
      div_recip <= 1'b0;
    end else begin
      state     <= state_next;
      cmd_code  <= cmd_code_next;
      idx       <= idx_next;
      k         <= k_next;
      d         <= d_next;
      mode_mat  <= mode_mat_next;
      div_recip <= div_recip_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and command words.
  always_comb begin
    state_next     = state;
    cmd_code_next  = cmd_code;
    idx_next       = idx;
    k_next         = k;
    d_next         = d;
    mode_mat_next  = mode_mat;
    div_recip_next = div_recip;
    cmd            = '0;
    cmd.mode_mat   = mode_mat;
    cmd.div_recip  = div_recip;
    cmd.div_sel    = d;
    cmd.cmd_code   = cmd_code;
    cmd.idx        = idx;
    cmd.k          = k;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture   = 1'b1;
          cmd_code_next = s_tuser;
          idx_next      = '0;
          k_next        = '0;
          if (s_tuser == hte_pkg::CMD_IDENT) begin
            cmd.load_ident = 1'b1;
          end else if (s_tuser inside {[hte_pkg::CMD_TRANSLATE:hte_pkg::CMD_ROT_Z]}) begin
            mode_mat_next = 1'b1;
            state_next    = S_MUL;
          end else if (s_tuser == hte_pkg::CMD_PERSP) begin
            if (stat.a_zero) begin
              state_next = S_OUT;
            end else begin
              div_recip_next = 1'b1;
              state_next     = S_DIVS;
            end
          end else if (s_tuser inside {hte_pkg::CMD_POINT, hte_pkg::CMD_HOMOG}) begin
            mode_mat_next = 1'b0;
            state_next    = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (k == 2'd3) begin
          state_next = S_RND;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_MUL;
        end
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        k_next     = '0;
        if (mode_mat) begin
          if (idx == 4'd15) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 4'd1;
            state_next = S_MUL;
          end
        end else if (idx == 4'd3) begin
          state_next = (cmd_code == hte_pkg::CMD_HOMOG) ? S_OUT : S_POST;
        end else begin
          idx_next   = idx + 4'd1;
          state_next = S_MUL;
        end
      end
      S_POST: begin
        div_recip_next = 1'b0;
        d_next         = '0;
        state_next     = stat.r3_zero ? S_OUT : S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy) begin
          if (div_recip) begin
            mode_mat_next = 1'b1;
            idx_next      = '0;
            k_next        = '0;
            state_next    = S_MUL;
          end else if (d == 2'd2) begin
            state_next = S_OUT;
          end else begin
            d_next     = d + 2'd1;
            state_next = S_DIVS;
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/hte_datapath.sv =====
// Datapath of the transform engine: matrix, multiply-accumulate, divider, output word.
module hte_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [hte_pkg::IN_DATA_W-1:0]       s_tdata,
  input  hte_pkg::hte_cmd_t                   cmd,
  output hte_pkg::hte_stat_t                  stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hte_pkg::IN_DATA_W-1:0]       m_tdata,
  output logic                                m_tuser
);

  localparam int W = hte_pkg::WORD_W;
  localparam int F = hte_pkg::FRAC_W;
  localparam int NW = hte_pkg::DIV_NUM_W;
  localparam int ACC_W = 2 * W + 2;
  localparam logic [5:0] DIV_STEPS = 6'(NW);

  logic signed [W-1:0] op_a, op_b, op_c, op_w, recip;
  logic signed [W-1:0] mat [16];
  logic signed [W-1:0] rowbuf [3];
  logic signed [W-1:0] vres [4];
  logic signed [W-1:0] quot [3];
  logic signed [2*W-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    return (v == hte_pkg::WMIN) ? hte_pkg::WMAX : -v;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // Entry of the elementary matrix for the current command.
  function automatic logic signed [W-1:0] t_entry(
    input logic [3:0] code, input logic [3:0] n,
    input logic signed [W-1:0] a, input logic signed [W-1:0] b,
    input logic signed [W-1:0] c, input logic signed [W-1:0] rc);
    logic signed [W-1:0] t;
    t = (n == 4'd0 || n == 4'd5 || n == 4'd10 || n == 4'd15) ? hte_pkg::ONE : '0;
    case (code)
      hte_pkg::CMD_TRANSLATE: begin
        if (n == 4'd12) t = a;
        if (n == 4'd13) t = b;
        if (n == 4'd14) t = c;
      end
      hte_pkg::CMD_SCALE: begin
        if (n == 4'd0) t = a;
        if (n == 4'd5) t = b;
        if (n == 4'd10) t = c;
      end
      hte_pkg::CMD_ROT_X: begin
        if (n == 4'd5 || n == 4'd10) t = a;
        if (n == 4'd6) t = neg_sat(b);
        if (n == 4'd9) t = b;
      end
      hte_pkg::CMD_ROT_Y: begin
        if (n == 4'd0 || n == 4'd10) t = a;
        if (n == 4'd2) t = neg_sat(b);
        if (n == 4'd8) t = b;
      end
      hte_pkg::CMD_ROT_Z: begin
        if (n == 4'd0 || n == 4'd5) t = a;
        if (n == 4'd1) t = neg_sat(b);
        if (n == 4'd4) t = b;
      end
      hte_pkg::CMD_PERSP: begin
        if (n == 4'd11) t = rc;
        if (n == 4'd14) t = neg_sat(a);
        if (n == 4'd15) t = '0;
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  // Operand selection for the single multiplier.
  logic [1:0] ri, rj;
  logic [3:0] rd_addr;
  logic signed [W-1:0] mat_rd, vec_k, mul_a, mul_b;
  assign ri = cmd.idx[3:2];
  assign rj = cmd.idx[1:0];
  assign rd_addr = cmd.mode_mat ? {ri, cmd.k} : {cmd.k, rj};
  assign mat_rd = mat[rd_addr];

  always_comb begin
    case (cmd.k)
      2'd0: vec_k = op_a;
      2'd1: vec_k = op_b;
      2'd2: vec_k = op_c;
      default: vec_k = (cmd.cmd_code == hte_pkg::CMD_POINT) ? hte_pkg::ONE : op_w;
    endcase
  end

  assign mul_a = cmd.mode_mat ? mat_rd : vec_k;
  assign mul_b = cmd.mode_mat ?
                 t_entry(cmd.cmd_code, {cmd.k, rj}, op_a, op_b, op_c, recip) : mat_rd;

  // Round to nearest at the binary point, then saturate.
  logic signed [ACC_W-1:0] rsum;
  logic signed [ACC_W-F-1:0] rsh;
  logic signed [W-1:0] rnd;
  assign rsum = acc + (ACC_W'(1) <<< (F - 1));
  assign rsh = rsum[ACC_W-1:F];
  always_comb begin
    if (rsh > (ACC_W-F)'(hte_pkg::WMAX)) rnd = hte_pkg::WMAX;
    else if (rsh < (ACC_W-F)'(hte_pkg::WMIN)) rnd = hte_pkg::WMIN;
    else rnd = rsh[W-1:0];
  end

  // Operand capture, products, accumulation and the matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 16; n++) mat[n] <= (n % 5 == 0) ? hte_pkg::ONE : '0;
    end else begin
      if (cmd.load_ident) begin
        for (int n = 0; n < 16; n++) mat[n] <= (n % 5 == 0) ? hte_pkg::ONE : '0;
      end
      if (cmd.rnd_en && cmd.mode_mat && rj == 2'd3) begin
        for (int c = 0; c < 3; c++) mat[{ri, 2'(c)}] <= rowbuf[c];
        mat[{ri, 2'd3}] <= rnd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_a <= s_tdata[W-1:0];
      op_b <= s_tdata[2*W-1:W];
      op_c <= s_tdata[3*W-1:2*W];
      op_w <= s_tdata[4*W-1:3*W];
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.acc_en) acc <= ((cmd.k == 2'd0) ? ACC_W'(0) : acc) + ACC_W'(prod);
    if (cmd.rnd_en) begin
      if (cmd.mode_mat) begin
        if (rj != 2'd3) rowbuf[rj] <= rnd;
      end else begin
        vres[rj] <= rnd;
      end
    end
  end

  // Restoring divider: one quotient bit a cycle, then a rounding-free finish.
  localparam logic [W:0] WMIN_MAG = (W+1)'(1) << (W - 1);
  logic [NW-1:0] div_num, div_quo, start_num;
  logic [W-1:0]  div_rem, div_den, start_den;
  logic [W:0]    rem_sh;
  logic [5:0]    div_cnt;
  logic          div_busy, div_neg, div_kind, start_neg;
  logic [1:0]    div_sel;
  logic [W:0]    qc;
  logic signed [W-1:0] qres;

  always_comb begin
    if (cmd.div_recip) begin
      start_den = mag(op_a);
      start_num = (NW'(1) << (2 * F)) + NW'(start_den >> 1);
      start_neg = op_a[W-1];
    end else begin
      start_den = mag(vres[3]);
      start_num = NW'({mag(vres[cmd.div_sel]), F'(0)}) + NW'(start_den >> 1);
      start_neg = vres[cmd.div_sel][W-1] != vres[3][W-1];
    end
  end

  assign rem_sh = {div_rem, div_num[NW-1]};
  assign qc = (div_quo > NW'(WMIN_MAG)) ? (W+1)'(WMIN_MAG) : div_quo[W:0];
  always_comb begin
    if (div_neg) qres = W'(-qc);
    else if (qc == WMIN_MAG) qres = hte_pkg::WMAX;
    else qres = qc[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 6'd0) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num  <= start_num;
      div_den  <= start_den;
      div_neg  <= start_neg;
      div_kind <= cmd.div_recip;
      div_sel  <= cmd.div_sel;
      div_rem  <= '0;
      div_quo  <= '0;
      div_cnt  <= DIV_STEPS;
    end else if (div_busy) begin
      if (div_cnt != 6'd0) begin
        div_num <= div_num << 1;
        div_cnt <= div_cnt - 6'd1;
        if (rem_sh >= {1'b0, div_den}) begin
          div_rem <= W'(rem_sh - {1'b0, div_den});
          div_quo <= {div_quo[NW-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh[W-1:0];
          div_quo <= {div_quo[NW-2:0], 1'b0};
        end
      end else if (div_kind) begin
        recip <= qres;
      end else begin
        quot[div_sel] <= qres;
      end
    end
  end

  // Output word register.
  logic r3_zero;
  logic signed [W-1:0] ox, oy, oz, ow;
  logic oflag;
  assign r3_zero = (vres[3] == '0);

  function automatic logic signed [W-1:0] sat_sign(input logic signed [W-1:0] v);
    if (v > 0) return hte_pkg::WMAX;
    if (v < 0) return hte_pkg::WMIN;
    return '0;
  endfunction

  always_comb begin
    case (cmd.cmd_code)
      hte_pkg::CMD_PERSP: begin
        ox = '0; oy = '0; oz = '0; ow = '0; oflag = 1'b1;
      end
      hte_pkg::CMD_POINT: begin
        ox = r3_zero ? sat_sign(vres[0]) : quot[0];
        oy = r3_zero ? sat_sign(vres[1]) : quot[1];
        oz = r3_zero ? sat_sign(vres[2]) : quot[2];
        ow = vres[3];
        oflag = r3_zero;
      end
      default: begin
        ox = vres[0]; oy = vres[1]; oz = vres[2]; ow = vres[3]; oflag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {ow, oz, oy, ox};
      m_tuser <= oflag;
    end
  end

  assign stat.a_zero   = (s_tdata[W-1:0] == '0);
  assign stat.r3_zero  = r3_zero;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

// ===== design/homogeneous_transform_engine.sv =====
// Top level of the homogeneous 4x4 transform engine.
//
// The slave stream takes one command word per handshake: s_tuser carries the
// command code, s_tdata the four Q16.16 operands. Matrix commands (identity,
// translate, scale, rotations, perspective) update the kept matrix and give no
// word, except perspective with a zero focal length, which gives a flagged
// all-zero word. Point and homogeneous commands give one word on the master
// stream with x, y, z, w in m_tdata and the zero-divisor flag in m_tuser.
// One shared 32x32 multiplier forms one product at a time. Identity is loaded
// as the command is taken; other matrix updates form each of the 16 entries
// from four products, and a perspective first divides for the reciprocal of
// its focal length. A homogeneous transform gives its word after the four
// dot products; a point transform then divides x, y and z by a nonzero w.
// One command is in work at a time; s_tready is high only when idle.
// Reset loads the identity matrix and empties the output register.
// The output register holds a finished word while the receiver stalls; the
// next command is still accepted, and a new word waits until the slot frees.
module homogeneous_transform_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operand_a, operand_b, operand_c, operand_w from the lowest bit up
  input  logic [hte_pkg::IN_DATA_W-1:0] s_tdata,
  // command
  input  logic [3:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_x, out_y, out_z, out_w from the lowest bit up
  output logic [hte_pkg::IN_DATA_W-1:0] m_tdata,
  // zero_divisor
  output logic                          m_tuser
);

  hte_pkg::hte_cmd_t  cmd;
  hte_pkg::hte_stat_t stat;

  // Sequencer.
  hte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  hte_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== design/hte_checker.sv =====
// Port-level checker of the transform engine and its bind.
`include "homogeneous_transform_engine_assert.svh"

module hte_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [3:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hte_pkg::IN_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);

  // A stalled word stays valid and unchanged.
  `HTE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `HTE_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

  // A vector command keeps the block busy in the next cycle.
  `HTE_ASSERT_NEXT(a_vec_busy, s_tvalid && s_tready &&
                   (s_tuser == hte_pkg::CMD_POINT || s_tuser == hte_pkg::CMD_HOMOG),
                   !s_tready)

  // A flagged word always carries a zero w.
  `HTE_ASSERT_NOW(a_flag_w, m_tvalid && m_tuser,
                  m_tdata[hte_pkg::IN_DATA_W-1:3*hte_pkg::WORD_W] == '0)

endmodule

bind homogeneous_transform_engine hte_checker u_hte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/tb.sv =====
// Self-checking testbench of the homogeneous 4x4 transform engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;
  localparam longint LONE = 64'sd1 << hte_pkg::FRAC_W;

  typedef struct {
    logic signed [hte_pkg::WORD_W-1:0] x, y, z, w;
    logic                              zdiv;
  } xform_word_t;

  // Tracks the kept matrix and holds the words the engine owes.
  class transform_scoreboard;
    longint      mat[16];
    xform_word_t owed[$];
    int          errors;

    function new();
      load_ident(mat);
      errors = 0;
    endfunction

    function longint clamp(longint v);
      return v > LMAX ? LMAX : (v < LMIN ? LMIN : v);
    endfunction

    function void load_ident(ref longint m[16]);
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? LONE : 0;
    endfunction

    // Exact sum of four products, rounded half up at the binary point.
    function longint dot(longint p0, longint p1, longint p2, longint p3,
                         longint q0, longint q1, longint q2, longint q3);
      longint whole;
      longint frac;
      longint pr[4];
      pr[0] = p0 * q0; pr[1] = p1 * q1; pr[2] = p2 * q2; pr[3] = p3 * q3;
      whole = 0;
      frac = 0;
      for (int k = 0; k < 4; k++) begin
        whole += pr[k] >>> hte_pkg::FRAC_W;
        frac += pr[k] & (LONE - 1);
      end
      frac += LONE / 2;
      return clamp(whole + (frac >>> hte_pkg::FRAC_W));
    endfunction

    // Quotient of magnitudes, rounded half away from zero, then saturated.
    function longint quot(longint num, longint den, bit neg);
      longint q;
      q = (num + den / 2) / den;
      return clamp(neg ? -q : q);
    endfunction

    function longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void concat(longint t[16]);
      longint prev[16];
      prev = mat;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          mat[i*4+j] = dot(prev[i*4], prev[i*4+1], prev[i*4+2], prev[i*4+3],
                           t[j], t[4+j], t[8+j], t[12+j]);
    endfunction

    function void note(logic [3:0] cmd, logic signed [31:0] ia, logic signed [31:0] ib,
                       logic signed [31:0] ic, logic signed [31:0] iw);
      longint a, b, c, w;
      longint t[16];
      longint r[4];
      xform_word_t res;
      a = longint'(ia); b = longint'(ib); c = longint'(ic); w = longint'(iw);
      load_ident(t);
      case (cmd)
        hte_pkg::CMD_IDENT: load_ident(mat);
        hte_pkg::CMD_TRANSLATE: begin
          t[12] = a; t[13] = b; t[14] = c;
          concat(t);
        end
        hte_pkg::CMD_SCALE: begin
          t[0] = a; t[5] = b; t[10] = c;
          concat(t);
        end
        hte_pkg::CMD_ROT_X: begin
          t[5] = a; t[10] = a; t[6] = clamp(-b); t[9] = b;
          concat(t);
        end
        hte_pkg::CMD_ROT_Y: begin
          t[0] = a; t[10] = a; t[2] = clamp(-b); t[8] = b;
          concat(t);
        end
        hte_pkg::CMD_ROT_Z: begin
          t[0] = a; t[5] = a; t[1] = clamp(-b); t[4] = b;
          concat(t);
        end
        hte_pkg::CMD_PERSP: begin
          if (a == 0) begin
            // A zero focal length leaves the matrix alone and flags a zero word.
            res = '{0, 0, 0, 0, 1'b1};
            owed.push_back(res);
          end else begin
            t[11] = quot(64'sd1 << (2 * hte_pkg::FRAC_W), absval(a), a < 0);
            t[14] = clamp(-a);
            t[15] = 0;
            concat(t);
          end
        end
        hte_pkg::CMD_POINT, hte_pkg::CMD_HOMOG: begin
          if (cmd == hte_pkg::CMD_POINT) w = LONE;
          for (int j = 0; j < 4; j++)
            r[j] = dot(a, b, c, w, mat[j], mat[4+j], mat[8+j], mat[12+j]);
          res.w = 32'(r[3]);
          res.zdiv = 1'b0;
          if (cmd == hte_pkg::CMD_HOMOG) begin
            res.x = 32'(r[0]); res.y = 32'(r[1]); res.z = 32'(r[2]);
          end else if (r[3] == 0) begin
            // Division by a zero w saturates by the sign of the dividend.
            res.zdiv = 1'b1;
            for (int j = 0; j < 3; j++) r[j] = r[j] > 0 ? LMAX : (r[j] < 0 ? LMIN : 0);
            res.x = 32'(r[0]); res.y = 32'(r[1]); res.z = 32'(r[2]);
          end else begin
            for (int j = 0; j < 3; j++)
              r[j] = quot(absval(r[j]) << hte_pkg::FRAC_W, absval(r[3]),
                          (r[j] < 0) != (r[3] < 0));
            res.x = 32'(r[0]); res.y = 32'(r[1]); res.z = 32'(r[2]);
          end
          owed.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check(logic [hte_pkg::IN_DATA_W-1:0] data, logic flag);
      xform_word_t exp_w;
      xform_word_t got;
      got.x = data[31:0]; got.y = data[63:32]; got.z = data[95:64]; got.w = data[127:96];
      got.zdiv = flag;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h w=%h flag=%b",
                 $time, got.x, got.y, got.z, got.w, got.zdiv);
        errors++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.x !== exp_w.x) begin
        $display("%0t: out_x expected %h actual %h", $time, exp_w.x, got.x); errors++;
      end
      if (got.y !== exp_w.y) begin
        $display("%0t: out_y expected %h actual %h", $time, exp_w.y, got.y); errors++;
      end
      if (got.z !== exp_w.z) begin
        $display("%0t: out_z expected %h actual %h", $time, exp_w.z, got.z); errors++;
      end
      if (got.w !== exp_w.w) begin
        $display("%0t: out_w expected %h actual %h", $time, exp_w.w, got.w); errors++;
      end
      if (got.zdiv !== exp_w.zdiv) begin
        $display("%0t: zero_divisor expected %b actual %b", $time, exp_w.zdiv, got.zdiv);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [hte_pkg::IN_DATA_W-1:0] s_tdata;
  logic [3:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [hte_pkg::IN_DATA_W-1:0] m_tdata;
  logic                          m_tuser;

  transform_scoreboard sb;
  bit calm;
  int words_seen;

  homogeneous_transform_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Offers one command word and notes it once the engine takes it.
  task automatic send_cmd(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic [31:0] w);
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {w, c, b, a};
    do @(posedge clk); while (!s_tready);
    sb.note(cmd, a, b, c, w);
  endtask

  function automatic logic [31:0] near(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Mostly moderate values, sometimes the whole word at random.
  function automatic logic [31:0] pick(int span);
    return ($urandom_range(0, 9) == 0) ? 32'($urandom) : near(span);
  endfunction

  // Collects result words; holds off once for a long stretch.
  initial begin
    int hold_left;
    bit held;
    m_tready = 1'b0;
    words_seen = 0;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        sb.check(m_tdata, m_tuser);
        words_seen++;
      end
      if (!held && words_seen >= 150) begin
        held = 1;
        m_tready <= 1'b0;
        hold_left = 4000;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int sel;
    int n;
    sb = new();
    calm = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: each command, field extremes and the divide corner cases.
    send_cmd(hte_pkg::CMD_HOMOG, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_cmd(hte_pkg::CMD_POINT, 32'h0001_8000, 32'hFFFE_0000, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_TRANSLATE, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0);
    send_cmd(hte_pkg::CMD_SCALE, 32'h0000_8000, 32'h0003_0000, 32'hFFFF_8000, 32'h0);
    send_cmd(hte_pkg::CMD_ROT_X, 32'h0000_B505, 32'h0000_B505, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_ROT_Y, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_ROT_Z, 32'hFFFF_0000, 32'h0000_0000, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_HOMOG, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'h0001_0000);
    send_cmd(hte_pkg::CMD_PERSP, 32'h0, 32'h1234_5678, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_IDENT, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_PERSP, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_POINT, 32'h0002_0000, 32'hFFFD_0000, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_POINT, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_POINT, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0);
    send_cmd(hte_pkg::CMD_IDENT, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_PERSP, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_PERSP, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_cmd(hte_pkg::CMD_HOMOG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000);
    send_cmd(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(4'd15, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cmd(hte_pkg::CMD_IDENT, 32'h0, 32'h0, 32'h0, 32'h0);

    // Random part: short chains of matrix updates between transforms.
    for (n = 0; n < 1130; n++) begin
      calm = (n >= 500 && n < 650);
      sel = $urandom_range(0, 99);
      if (sel < 8)
        send_cmd(hte_pkg::CMD_IDENT, 32'($urandom), 32'($urandom), 32'($urandom),
                 32'($urandom));
      else if (sel < 18)
        send_cmd(hte_pkg::CMD_TRANSLATE, pick(8 << hte_pkg::FRAC_W),
                 pick(8 << hte_pkg::FRAC_W), pick(8 << hte_pkg::FRAC_W), 32'($urandom));
      else if (sel < 26)
        send_cmd(hte_pkg::CMD_SCALE, pick(2 << hte_pkg::FRAC_W),
                 pick(2 << hte_pkg::FRAC_W), pick(2 << hte_pkg::FRAC_W), 32'($urandom));
      else if (sel < 41)
        send_cmd(4'(hte_pkg::CMD_ROT_X + $urandom_range(0, 2)), pick(1 << hte_pkg::FRAC_W),
                 pick(1 << hte_pkg::FRAC_W), 32'($urandom), 32'($urandom));
      else if (sel < 49)
        send_cmd(hte_pkg::CMD_PERSP,
                 ($urandom_range(0, 7) == 0) ? 32'h0 : pick(16 << hte_pkg::FRAC_W),
                 32'($urandom), 32'($urandom), 32'($urandom));
      else if (sel < 73)
        send_cmd(hte_pkg::CMD_POINT, pick(16 << hte_pkg::FRAC_W),
                 pick(16 << hte_pkg::FRAC_W),
                 ($urandom_range(0, 5) == 0) ? 32'h0 : pick(16 << hte_pkg::FRAC_W),
                 32'($urandom));
      else if (sel < 97)
        send_cmd(hte_pkg::CMD_HOMOG, pick(16 << hte_pkg::FRAC_W),
                 pick(16 << hte_pkg::FRAC_W), pick(16 << hte_pkg::FRAC_W),
                 pick(2 << hte_pkg::FRAC_W));
      else
        send_cmd(4'($urandom_range(9, 15)), 32'($urandom), 32'($urandom), 32'($urandom),
                 32'($urandom));
    end
    calm = 0;
    s_tvalid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS homogeneous_transform_engine");
    end else begin
      $display("FAIL homogeneous_transform_engine");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #60ms;
    $display("FAIL homogeneous_transform_engine");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/hte_pkg.sv
design/hte_ctrl.sv
design/hte_datapath.sv
design/homogeneous_transform_engine.sv
design/hte_checker.sv
dv/tb.sv
